/* rtl/lap3_pkg.sv */
// Shared types, constants and helpers for the 3x3 Laplacian image filter.
// Used by every module of the filter; depends on nothing else.
`default_nettype none
package lap3_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;

	localparam int PIX_W = 8;
	localparam int DIM_W = 8;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int LINE_W = 2 * PIX_W;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam int OUT_DATA_BITS = PIX_W + ROW_W + COL_W;
	localparam int OUT_DATA_W = ((OUT_DATA_BITS + 7) / 8) * 8;

	// Pixel position inside the frame.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pos_t;

	// Last column and last row index of the frame in use.
	typedef struct packed {
		logic [DIM_W-1:0] w_last;
		logic [DIM_W-1:0] h_last;
	} lim_t;

	// Clamp a frame dimension to [3, hi] and return the last index.
	function automatic logic [DIM_W-1:0] last_index(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] d;
		if (v < DIM_W'(3)) begin
			d = DIM_W'(3);
		end else if (v > hi) begin
			d = hi;
		end else begin
			d = v;
		end
		return d - DIM_W'(1);
	endfunction

endpackage
`default_nettype wire

/* rtl/lap3_pos_counter.sv */
// Raster position counters for the 3x3 Laplacian filter.
// Depends on lap3_pkg for the position and limit types.
`default_nettype none
module lap3_pos_counter (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic          frame_start,
	input  wire lap3_pkg::lim_t lim,
	output lap3_pkg::pos_t     pos
);

	logic [lap3_pkg::ROW_W-1:0] row_q;
	logic [lap3_pkg::COL_W-1:0] col_q;
	logic col_wrap;
	logic row_wrap;

	// A frame start forces the current beat to position (0,0).
	always_comb begin
		pos.row = frame_start ? '0 : row_q;
		pos.col = frame_start ? '0 : col_q;
		col_wrap = {1'b0, pos.col} >= lim.w_last;
		row_wrap = {1'b0, pos.row} >= lim.h_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (step) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : pos.row + lap3_pkg::ROW_W'(1);
			end else begin
				col_q <= pos.col + lap3_pkg::COL_W'(1);
				row_q <= pos.row;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/lap3_line_store.sv */
// Two-row line store for the 3x3 Laplacian filter: one write and one
// registered read per cycle, with write-to-read forwarding. Uses lap3_pkg.
`default_nettype none
module lap3_line_store (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [lap3_pkg::COL_W-1:0]  wr_addr,
	input  wire logic [lap3_pkg::LINE_W-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [lap3_pkg::COL_W-1:0]  rd_addr,
	output logic      [lap3_pkg::LINE_W-1:0] rd_data
);

	logic [lap3_pkg::LINE_W-1:0] mem [lap3_pkg::MAX_WIDTH];
	logic [lap3_pkg::LINE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read of the column written in the same cycle takes the new data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

/* rtl/lap3_kernel.sv */
// Window columns and Laplacian kernel sum for the 3x3 filter.
// Depends on lap3_pkg for widths.
`default_nettype none
module lap3_kernel (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [lap3_pkg::PIX_W-1:0]  pixel,
	input  wire logic [lap3_pkg::LINE_W-1:0] above,
	output logic      [lap3_pkg::PIX_W-1:0]  sum,
	output logic      [lap3_pkg::LINE_W-1:0] line_wr
);

	localparam int P = lap3_pkg::PIX_W;

	// Each column holds row-2 in the low byte, then row-1, then the row.
	logic [3*P-1:0] win0_q;
	logic [3*P-1:0] win1_q;
	logic [3*P-1:0] cur;
	logic [P-1:0] up, mid, down, left, right;

	always_comb begin
		cur = {pixel, above[P-1:0], above[2*P-1:P]};
		up = win0_q[P-1:0];
		mid = win0_q[2*P-1:P];
		down = win0_q[3*P-1:2*P];
		left = win1_q[2*P-1:P];
		right = cur[2*P-1:P];
		// Eight-bit arithmetic gives the wrapped result directly.
		sum = up + down + left + right - {mid[P-3:0], 2'b00};
		line_wr = {above[P-1:0], pixel};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (advance) begin
			win1_q <= win0_q;
			win0_q <= cur;
		end
	end

endmodule
`default_nettype wire

/* rtl/laplacian_3x3_image_filter.sv */
// 3x3 Laplacian image filter: pixels wait in the first stage, results in the output register.
// One pixel per cycle unless results stall, as the line store does one read and write a cycle.
// Reset (arst_n low) clears counters, window columns, valid flags and the size registers (128).
// The line store is not cleared; no clearing pass is run.
// Depends on lap3_pkg, lap3_pos_counter, lap3_line_store and lap3_kernel.
`default_nettype none
module laplacian_3x3_image_filter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port.
	input  wire logic                              cfg_we,
	input  wire logic [lap3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lap3_pkg::DIM_W-1:0]        cfg_data,
	// Pixel input stream.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [lap3_pkg::PIX_W-1:0]        s_tdata,  // pixel
	input  wire logic [0:0]                        s_tuser,  // frame_start
	// Result stream.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [lap3_pkg::OUT_DATA_W-1:0]   m_tdata,  // filtered, out_row, out_col, zeros
	output logic                                   m_tlast   // frame_last
);

	localparam int P = lap3_pkg::PIX_W;
	localparam int RW = lap3_pkg::ROW_W;
	localparam int CW = lap3_pkg::COL_W;

	// Size registers. Values out of range are clamped when used.
	logic [lap3_pkg::DIM_W-1:0] width_q;
	logic [lap3_pkg::DIM_W-1:0] height_q;
	lap3_pkg::lim_t lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= lap3_pkg::DIM_W'(lap3_pkg::MAX_WIDTH);
			height_q <= lap3_pkg::DIM_W'(lap3_pkg::MAX_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				lap3_pkg::REG_IMAGE_WIDTH: width_q <= cfg_data;
				lap3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		lim.w_last = lap3_pkg::last_index(width_q, lap3_pkg::DIM_W'(lap3_pkg::MAX_WIDTH));
		lim.h_last = lap3_pkg::last_index(height_q, lap3_pkg::DIM_W'(lap3_pkg::MAX_HEIGHT));
	end

	// Handshake. Stage 1 holds the accepted pixel while the line store
	// read completes; it retires into the output register, or simply
	// retires when it gives no result. A new beat is taken whenever
	// stage 1 is empty or retiring, so the input stops only while stage 1
	// holds a result and the output register holds a stalled beat.
	logic in_acc;
	logic valid_s1;
	logic emit_s1;
	logic adv_s1;
	logic out_v_q;

	assign adv_s1 = valid_s1 && (!emit_s1 || !out_v_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign in_acc = s_tvalid && s_tready;

	// Position of the beat being accepted.
	lap3_pkg::pos_t pos;

	lap3_pos_counter u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.step(in_acc),
		.frame_start(s_tuser[0]),
		.lim(lim),
		.pos(pos)
	);

	// Stage 1 registers.
	logic [P-1:0] pix_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= s_tdata;
			row_s1 <= pos.row;
			col_s1 <= pos.col;
		end
	end

	// The line store is read at the accepted column and written back when
	// stage 1 retires; forwarding covers two beats at the same column.
	logic [lap3_pkg::LINE_W-1:0] above_s1;
	logic [lap3_pkg::LINE_W-1:0] line_wr;
	logic [P-1:0] sum;

	lap3_line_store u_line (
		.clk(clk),
		.wr_en(adv_s1),
		.wr_addr(col_s1),
		.wr_data(line_wr),
		.rd_en(in_acc),
		.rd_addr(pos.col),
		.rd_data(above_s1)
	);

	lap3_kernel u_kernel (
		.clk(clk),
		.arst_n(arst_n),
		.advance(adv_s1),
		.pixel(pix_s1),
		.above(above_s1),
		.sum(sum),
		.line_wr(line_wr)
	);

	// A result exists once three rows and three columns have been seen.
	logic last_s1;

	always_comb begin
		emit_s1 = (row_s1 >= RW'(2)) && (col_s1 >= CW'(2));
		last_s1 = ({1'b0, row_s1} >= lim.h_last) && ({1'b0, col_s1} >= lim.w_last);
	end

	// Output register.
	logic [P-1:0] filt_q;
	logic [RW-1:0] orow_q;
	logic [CW-1:0] ocol_q;
	logic olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			filt_q <= sum;
			orow_q <= row_s1 - RW'(1);
			ocol_q <= col_s1 - CW'(1);
			olast_q <= last_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {{(lap3_pkg::OUT_DATA_W - lap3_pkg::OUT_DATA_BITS){1'b0}},
		ocol_q, orow_q, filt_q};
	assign m_tlast = olast_q;

endmodule
`default_nettype wire

/* rtl/lap3_checker.sv */
// Port-level checker for the 3x3 Laplacian filter, bound to the top level.
// Depends on lap3_pkg for port widths.
`default_nettype none
module lap3_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [lap3_pkg::OUT_DATA_W-1:0]   m_tdata,
	input wire logic                              m_tlast
);

	localparam int P = lap3_pkg::PIX_W;
	localparam int RW = lap3_pkg::ROW_W;
	localparam int CW = lap3_pkg::COL_W;

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// With no result waiting, the input side is always open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with an empty output");

	// Results never lie in the top row or the left column.
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[P+RW-1:P] != '0) && (m_tdata[P+RW+CW-1:P+RW] != '0))
		else $error("result on a border pixel");

	// Padding bits of the result stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[lap3_pkg::OUT_DATA_W-1:lap3_pkg::OUT_DATA_BITS] == '0)
		else $error("result padding not zero");

endmodule

bind laplacian_3x3_image_filter lap3_checker u_lap3_checker (.*);
`default_nettype wire

/* tb/laplacian_3x3_image_filter_tb.sv */
// Self-checking testbench for laplacian_3x3_image_filter: pixel streams in, Laplacian beats out.
// Depends on lap3_pkg for port widths and register indexes; needs nothing but the RTL.
module laplacian_3x3_image_filter_tb;

	// A stretch this long with no beat on either side means the block is stuck.
	localparam int STALL_LIMIT = 2000;
	// Settle time after the last owed beat, for anything still in flight.
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int ROW_LSB = lap3_pkg::PIX_W;
	localparam int COL_LSB = lap3_pkg::PIX_W + lap3_pkg::ROW_W;

	// One filtered beat as the block should deliver it.
	typedef struct {
		logic [lap3_pkg::PIX_W-1:0] value;
		logic [lap3_pkg::ROW_W-1:0] row;
		logic [lap3_pkg::COL_W-1:0] col;
		logic                       last;
	} lap_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lap3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lap3_pkg::DIM_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [lap3_pkg::PIX_W-1:0] s_tdata = '0;   // pixel
	logic [0:0] s_tuser = '0;                   // frame_start
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [lap3_pkg::OUT_DATA_W-1:0] m_tdata;   // filtered, out_row, out_col, zero fill
	logic m_tlast;                              // frame_last

	// Our own copy of the filter state: the two rows above, the two previous window
	// columns, the position of the next pixel and the two size registers.
	logic [15:0] rows_above [0:127];
	logic [23:0] prev_cols [0:1];
	logic [7:0] next_row;
	logic [7:0] next_col;
	logic [7:0] width_reg;
	logic [7:0] height_reg;

	// Filtered beats still owed by the block, oldest first.
	lap_result_t pending_results[$];

	int pixels_sent = 0;
	int results_checked = 0;
	int errors = 0;
	int stall_cycles = 0;
	// Chance in percent that the pixel side or the result side holds off in a cycle.
	int src_idle_pct = 12;
	int snk_idle_pct = 46;

	laplacian_3x3_image_filter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A size register in use is held to the range 3 to 128.
	function automatic logic [7:0] clamp_dim(input logic [7:0] v);
		if (v < 8'd3) begin
			return 8'd3;
		end
		if (v > 8'd128) begin
			return 8'd128;
		end
		return v;
	endfunction

	// Random pixel, with the two signed extremes showing up more often than chance would give.
	function automatic logic [7:0] rand_pixel();
		if ($urandom_range(99) < 12) begin
			return $urandom_range(1) ? 8'h7F : 8'h80;
		end
		return 8'($urandom_range(255));
	endfunction

	// Mostly small sizes keep frames short; now and then a value below 3 or a larger size.
	function automatic logic [7:0] pick_dim(input int usual_hi, input int big_hi);
		if ($urandom_range(99) < 10) begin
			return 8'($urandom_range(2));
		end
		if ($urandom_range(99) < 10) begin
			return 8'($urandom_range(big_hi, usual_hi + 1));
		end
		return 8'($urandom_range(usual_hi, 3));
	endfunction

	// Advance the filter state by one accepted pixel and queue the beat it produces, if any.
	// The window is centred on the previous column of the row above the incoming pixel.
	task automatic predict_laplacian(input logic [7:0] pix, input logic frame_start);
		logic [7:0] w;
		logic [7:0] h;
		logic [7:0] r;
		logic [7:0] c;
		logic [7:0] mid;
		logic [7:0] sum;
		logic [15:0] above;
		logic [23:0] cur;
		lap_result_t res;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		if (frame_start) begin
			next_row = 8'd0;
			next_col = 8'd0;
		end
		r = next_row;
		c = next_col;
		above = (c < 8'd128) ? rows_above[c[6:0]] : 16'h0000;
		// Column as it now stands: two rows up in the low byte, the new pixel on top.
		cur = {pix, above[7:0], above[15:8]};
		if (r >= 8'd2 && c >= 8'd2) begin
			mid = prev_cols[0][15:8];
			// Eight-bit arithmetic gives the wrapped result directly.
			sum = prev_cols[0][7:0] + prev_cols[0][23:16] + prev_cols[1][15:8] + cur[15:8]
				- {mid[5:0], 2'b00};
			res.value = sum;
			res.row = 7'(r - 8'd1);
			res.col = 7'(c - 8'd1);
			res.last = (r >= h - 8'd1) && (c >= w - 8'd1);
			pending_results.push_back(res);
		end
		prev_cols[1] = prev_cols[0];
		prev_cols[0] = cur;
		if (c < 8'd128) begin
			rows_above[c[6:0]] = {above[7:0], pix};
		end
		if (c >= w - 8'd1) begin
			next_col = 8'd0;
			next_row = (r >= h - 8'd1) ? 8'd0 : r + 8'd1;
		end else begin
			next_col = c + 8'd1;
		end
	endtask

	// Offer one pixel beat, with random idle cycles first, and return once it is accepted.
	// tvalid stays high on return so that back-to-back beats need no extra edge.
	task automatic send_pixel(input logic [7:0] pix, input logic frame_start);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tuser <= frame_start;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		predict_laplacian(pix, frame_start);
		pixels_sent++;
	endtask

	// Stop sending, wait for every owed beat, then let the pipeline empty of pixels
	// that produce no beat. The block is idle afterwards and may be reconfigured.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write. The trailing edge keeps two writes in a row from driving
	// cfg_we twice in the same time step.
	task automatic write_reg(input logic [lap3_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lap3_pkg::REG_IMAGE_WIDTH) begin
			width_reg = val;
		end else begin
			height_reg = val;
		end
		@(posedge clk);
	endtask

	// Keep sending random pixels until the position counters wrap to the top left corner.
	task automatic send_rest_of_frame();
		do begin
			send_pixel(rand_pixel(), 1'b0);
		end while (!(next_row == 8'd0 && next_col == 8'd0));
	endtask

	// A 3x3 frame whose only interior pixel has the given value and whose neighbors above,
	// below, left and right share another; the corners are random and must not matter.
	task automatic send_cross(input logic [7:0] centre, input logic [7:0] edge_pix,
			input logic frame_start);
		for (int k = 0; k < 9; k++) begin
			if (k == 4) begin
				send_pixel(centre, frame_start && k == 0);
			end else if (k % 2 == 1) begin
				send_pixel(edge_pix, 1'b0);
			end else begin
				send_pixel(rand_pixel(), frame_start && k == 0);
			end
		end
	endtask

	// Sizes below the minimum clamp to a 3x3 frame. The sums at the signed extremes wrap,
	// and the second and third frames start only because the counters wrapped.
	task automatic test_kernel_extremes();
		drain_results();
		write_reg(lap3_pkg::REG_IMAGE_WIDTH, 8'd0);
		write_reg(lap3_pkg::REG_IMAGE_HEIGHT, 8'd2);
		send_cross(8'h80, 8'h7F, 1'b1);
		send_cross(8'h7F, 8'h80, 1'b0);
		send_cross(8'h80, 8'h80, 1'b0);
	endtask

	// Sizes change in the middle of a frame and take effect at once. The sender holds
	// back until every owed beat has arrived before each change. Width only grows while
	// the first row is still coming in, so no stale line store entry is ever used.
	task automatic test_config_mid_frame();
		drain_results();
		write_reg(lap3_pkg::REG_IMAGE_WIDTH, 8'd8);
		write_reg(lap3_pkg::REG_IMAGE_HEIGHT, 8'd6);
		send_pixel(rand_pixel(), 1'b1);
		while (!(next_row == 8'd3 && next_col == 8'd5)) begin
			send_pixel(rand_pixel(), 1'b0);
		end
		drain_results();
		// The column counter is already past the new last column and wraps on the next pixel.
		write_reg(lap3_pkg::REG_IMAGE_WIDTH, 8'd4);
		repeat (6) send_pixel(rand_pixel(), 1'b0);
		drain_results();
		// The current row is at or past the new last row, so the frame ends with it.
		write_reg(lap3_pkg::REG_IMAGE_HEIGHT, 8'd3);
		send_rest_of_frame();
		send_pixel(rand_pixel(), 1'b1);
		repeat (2) send_pixel(rand_pixel(), 1'b0);
		drain_results();
		write_reg(lap3_pkg::REG_IMAGE_WIDTH, 8'd10);
		write_reg(lap3_pkg::REG_IMAGE_HEIGHT, 8'd9);
		while (next_row != 8'd4) begin
			send_pixel(rand_pixel(), 1'b0);
		end
		drain_results();
		write_reg(lap3_pkg::REG_IMAGE_HEIGHT, 8'd5);
		send_rest_of_frame();
	endtask

	// frame_start in the middle of a frame throws away the position and begins again.
	task automatic test_frame_restart();
		drain_results();
		write_reg(lap3_pkg::REG_IMAGE_WIDTH, 8'd6);
		write_reg(lap3_pkg::REG_IMAGE_HEIGHT, 8'd5);
		send_pixel(rand_pixel(), 1'b1);
		repeat (14) send_pixel(rand_pixel(), 1'b0);
		send_pixel(rand_pixel(), 1'b1);
		repeat (9) send_pixel(rand_pixel(), 1'b0);
		send_pixel(rand_pixel(), 1'b1);
		send_rest_of_frame();
	endtask

	// A width above the maximum clamps to 128: one full row goes in at that width, then
	// the width shrinks and the frame ends two rows later. The beats carry row 1 only if
	// the first row wrapped after column 127.
	task automatic test_widest_row();
		drain_results();
		write_reg(lap3_pkg::REG_IMAGE_WIDTH, 8'd200);
		write_reg(lap3_pkg::REG_IMAGE_HEIGHT, 8'd3);
		send_pixel(rand_pixel(), 1'b1);
		while (next_row == 8'd0) begin
			send_pixel(rand_pixel(), 1'b0);
		end
		drain_results();
		write_reg(lap3_pkg::REG_IMAGE_WIDTH, 8'd5);
		send_rest_of_frame();
	endtask

	// Random frames of random small sizes. Some frames are cut by an early frame_start,
	// some see a size change part way through, and a few start without frame_start.
	task automatic test_random_frames(input int n_items);
		int start;
		int k;
		int restart_at;
		int change_at;
		logic fs;
		start = pixels_sent;
		while (pixels_sent - start < n_items) begin
			drain_results();
			write_reg(lap3_pkg::REG_IMAGE_WIDTH, pick_dim(12, 32));
			write_reg(lap3_pkg::REG_IMAGE_HEIGHT, pick_dim(8, 12));
			restart_at = ($urandom_range(99) < 20) ? $urandom_range(30, 1) : -1;
			change_at = ($urandom_range(99) < 20) ? $urandom_range(40, 1) : -1;
			k = 0;
			do begin
				if (k == change_at) begin
					drain_results();
					if ($urandom_range(1)) begin
						write_reg(lap3_pkg::REG_IMAGE_HEIGHT, 8'($urandom_range(10)));
					end else if (next_row == 8'd0) begin
						write_reg(lap3_pkg::REG_IMAGE_WIDTH, 8'($urandom_range(16)));
					end else begin
						// Past the first row the width may only stay or shrink.
						write_reg(lap3_pkg::REG_IMAGE_WIDTH,
							8'($urandom_range(clamp_dim(width_reg), 3)));
					end
				end
				fs = (k == 0) ? ($urandom_range(99) < 85) : (k == restart_at);
				send_pixel(rand_pixel(), fs);
				k++;
			end while (!(next_row == 8'd0 && next_col == 8'd0));
		end
	endtask

	// Result side: random back-pressure, and each accepted beat is checked field by field
	// against the oldest owed result.
	always @(posedge clk) begin : check_results
		lap_result_t want;
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: tdata %h tlast %b", m_tdata, m_tlast);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[ROW_LSB-1:0] !== want.value) begin
					$error("filtered mismatch: expected %0d, actual %0d",
						$signed(want.value), $signed(m_tdata[ROW_LSB-1:0]));
					errors++;
				end
				if (m_tdata[COL_LSB-1:ROW_LSB] !== want.row) begin
					$error("out_row mismatch: expected %0d, actual %0d",
						want.row, m_tdata[COL_LSB-1:ROW_LSB]);
					errors++;
				end
				if (m_tdata[COL_LSB+lap3_pkg::COL_W-1:COL_LSB] !== want.col) begin
					$error("out_col mismatch: expected %0d, actual %0d",
						want.col, m_tdata[COL_LSB+lap3_pkg::COL_W-1:COL_LSB]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("frame_last mismatch: expected %b, actual %b", want.last, m_tlast);
					errors++;
				end
				results_checked++;
			end
		end
	end

	// Watchdog: any beat on either side restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("laplacian_3x3_image_filter_tb failed");
				$finish;
			end
		end
	end

	initial begin
		// The line store model starts at zero; entries are only used after being written.
		for (int i = 0; i < 128; i++) begin
			rows_above[i] = 16'h0000;
		end
		prev_cols[0] = 24'h0;
		prev_cols[1] = 24'h0;
		next_row = 8'd0;
		next_col = 8'd0;
		width_reg = 8'd128;
		height_reg = 8'd128;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pixels idle now and then, results are held back often.
		test_kernel_extremes();
		test_config_mid_frame();
		test_random_frames(30);

		// The other way round.
		src_idle_pct = 46;
		snk_idle_pct = 12;
		test_frame_restart();
		test_widest_row();
		test_random_frames(30);

		// Full rate on both sides.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_frames(40);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d pixels and checked %0d filtered beats on frames from 3x3 up to",
			pixels_sent, results_checked);
		$display("128 wide, with clamped and mid-frame sizes, restarts and stalls.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("laplacian_3x3_image_filter_tb passed");
		end else begin
			$display("laplacian_3x3_image_filter_tb failed");
		end
		$finish;
	end

endmodule
